// ----- hw/rtl/cpts_pkg.sv -----
package cpts_pkg;

  // coordinate, radius and difference widths
  localparam int CW    = 32;
  localparam int RW    = 31;
  localparam int DW    = CW + 1;
  // squared distance and its square root
  localparam int SQW   = 2 * DW;
  localparam int ROOTW = SQW / 2;
  // tangent direction vector (signed) and its magnitude
  localparam int NW    = SQW + 2;
  localparam int MW    = NW - 1;
  // split of the magnitude for the radius multiply
  localparam int LOW_W = (MW + 1) / 2;
  localparam int HIGH_W = MW - LOW_W;
  localparam int PW    = MW + RW;
  // rounding divider
  localparam int NUMW  = PW + 2;
  localparam int DENW  = SQW + 1;
  localparam int QW    = 41;
  localparam int REMW  = DENW + 1;
  localparam int SUMW  = QW + 2;

  localparam int SQRT_LAT = ROOTW + 1;
  localparam int DIV_LAT  = QW + 1;

  localparam logic [QW-1:0] OFFSET_CLIP = {1'b1, {(QW - 1){1'b0}}};

  // configuration register indexes
  localparam int IDXW = 1;
  localparam logic [IDXW-1:0] REG_COINCIDE_LIMIT = 1'b0;
  localparam logic [IDXW-1:0] REG_TANGENT_SLACK  = 1'b1;

  localparam logic [CW-1:0] COINCIDE_RESET = '0;
  localparam logic [CW-1:0] SLACK_RESET    = CW'(4);

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(2147483647);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  typedef struct packed {
    logic found;
    logic crossing;
    logic side;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
  } pts_t;

  // center plus or minus offset magnitude, saturated to the coordinate range
  function automatic logic signed [CW-1:0] offset_sat(logic signed [CW-1:0] c,
                                                      logic [QW-1:0] m, logic neg);
    logic signed [SUMW-1:0] s;
    logic signed [SUMW-1:0] mm;
    mm = $signed(SUMW'(m));
    s = neg ? SUMW'(c) - mm : SUMW'(c) + mm;
    if (s > SAT_HI) begin
      return CW'(SAT_HI);
    end else if (s < SAT_LO) begin
      return CW'(SAT_LO);
    end
    return $signed(s[CW-1:0]);
  endfunction

endpackage

// ----- hw/rtl/cpts_isqrt.sv -----
module cpts_isqrt import cpts_pkg::*; (
  input  logic             clk,
  input  logic [SQW-1:0]   radicand,
  output logic [ROOTW-1:0] root
);

  logic [SQW-1:0]   rem_q  [0:ROOTW];
  logic [ROOTW-1:0] root_q [0:ROOTW];

  always_ff @(posedge clk) begin
    rem_q[0]  <= radicand;
    root_q[0] <= '0;
  end

  // one root bit per stage, msb first
  for (genvar i = 0; i < ROOTW; i++) begin : g_stage
    localparam int B = ROOTW - 1 - i;
    logic [SQW-1:0] trial;
    assign trial = (SQW'(root_q[i]) << (B + 1)) | (SQW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rem_q[i] >= trial) begin
        rem_q[i+1]  <= rem_q[i] - trial;
        root_q[i+1] <= root_q[i] | (ROOTW'(1) << B);
      end else begin
        rem_q[i+1]  <= rem_q[i];
        root_q[i+1] <= root_q[i];
      end
    end
  end

  assign root = root_q[ROOTW];

endmodule

// ----- hw/rtl/cpts_div.sv -----
module cpts_div import cpts_pkg::*; (
  input  logic            clk,
  input  logic [NUMW-1:0] numer,
  input  logic [DENW-1:0] denom,
  output logic [QW-1:0]   quot
);

  logic [REMW-1:0] rem_q [0:QW];
  logic [QW-1:0]   low_q [0:QW];
  logic [QW-1:0]   quo_q [0:QW];
  logic [DENW-1:0] den_q [0:QW];
  logic            ovf_q [0:QW];

  // quotient of 2^QW or more is clipped anyway
  always_ff @(posedge clk) begin
    rem_q[0] <= REMW'(numer[NUMW-1:QW]);
    low_q[0] <= numer[QW-1:0];
    quo_q[0] <= '0;
    den_q[0] <= denom;
    ovf_q[0] <= REMW'(numer[NUMW-1:QW]) >= REMW'(denom);
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic [REMW-1:0] trial;
    assign trial = {rem_q[j][REMW-2:0], low_q[j][B]};

    always_ff @(posedge clk) begin
      low_q[j+1] <= low_q[j];
      den_q[j+1] <= den_q[j];
      ovf_q[j+1] <= ovf_q[j];
      if (trial >= REMW'(den_q[j])) begin
        rem_q[j+1] <= trial - REMW'(den_q[j]);
        quo_q[j+1] <= quo_q[j] | (QW'(1) << B);
      end else begin
        rem_q[j+1] <= trial;
        quo_q[j+1] <= quo_q[j];
      end
    end
  end

  assign quot = (ovf_q[QW] || quo_q[QW] > OFFSET_CLIP) ? OFFSET_CLIP : quo_q[QW];

endmodule

// ----- hw/rtl/circle_pair_tangent_segments_top.sv -----
// Common tangent segments of two circles.
//
// An item (two centers and two radii, Q16.16) is taken at a clock edge with
// start high and busy low. Each item is worked as four slots, one per cycle:
// crossing minus, crossing plus, outer minus, outer plus. busy stays high until
// the last slot of an item is issued, so no new item is taken before that.
// Results leave on the output ports for one cycle each, marked by valid, with
// last set on the final result of the item. Slots of a skipped group send
// nothing; when no tangent exists one result with found clear is sent.
// The square root is a 34-stage pipeline and the rounding dividers 42-stage
// ones; after an input register each stage works out one bit. The pipeline
// takes a slot in every cycle and has no stall: the receiver must take each
// result when valid is high.
// Registers are written through wr_en / wr_index / wr_data; the user must write
// them only while no item is in flight, which the block does not enforce. rst
// clears the pipeline valids and sets coincide_limit = 0 and tangent_slack = 4.
module circle_pair_tangent_segments_top import cpts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] first_center_x,
  input  logic signed [CW-1:0] first_center_y,
  input  logic [RW-1:0]        first_radius,
  input  logic signed [CW-1:0] second_center_x,
  input  logic signed [CW-1:0] second_center_y,
  input  logic [RW-1:0]        second_radius,
  input  logic                 wr_en,
  input  logic [IDXW-1:0]      wr_index,
  input  logic [CW-1:0]        wr_data,
  output logic                 valid,
  output logic                 found,
  output logic                 crossing,
  output logic                 side,
  output logic signed [CW-1:0] touch_first_x,
  output logic signed [CW-1:0] touch_first_y,
  output logic signed [CW-1:0] touch_second_x,
  output logic signed [CW-1:0] touch_second_y,
  output logic                 last
);

  typedef struct packed {
    ctl_t                 ctl;
    pts_t                 pts;
    logic [RW-1:0]        r1;
    logic [RW-1:0]        r2;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] rd;
    logic [SQW-1:0]       d;
  } geo_t;

  typedef struct packed {
    ctl_t           ctl;
    pts_t           pts;
    logic [RW-1:0]  r1;
    logic [RW-1:0]  r2;
    logic [SQW-1:0] d;
  } rest_t;

  typedef struct packed {
    ctl_t ctl;
    pts_t pts;
    logic negx;
    logic negy;
  } fin_t;

  // configuration
  logic [CW-1:0] coincide_limit;
  logic [CW-1:0] tangent_slack;

  always_ff @(posedge clk) begin
    if (rst) begin
      coincide_limit <= COINCIDE_RESET;
      tangent_slack  <= SLACK_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_COINCIDE_LIMIT: coincide_limit <= wr_data;
        REG_TANGENT_SLACK:  tangent_slack  <= wr_data;
        default: ;
      endcase
    end
  end

  // input register and slot issue
  logic          accept;
  logic [1:0]    cnt;
  logic          a_valid;
  logic [1:0]    a_slot;
  pts_t          a_pts;
  logic [RW-1:0] a_r1, a_r2;

  assign busy   = cnt != '0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      a_valid <= 1'b0;
      a_slot  <= '0;
    end else if (accept) begin
      cnt     <= 2'd1;
      a_valid <= 1'b1;
      a_slot  <= '0;
    end else if (cnt != '0) begin
      cnt     <= cnt + 2'd1;
      a_valid <= 1'b1;
      a_slot  <= cnt;
    end else begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pts.x1 <= first_center_x;
      a_pts.y1 <= first_center_y;
      a_pts.x2 <= second_center_x;
      a_pts.y2 <= second_center_y;
      a_r1     <= first_radius;
      a_r2     <= second_radius;
    end
  end

  // stage b: differences
  logic                 b_valid;
  logic [1:0]           b_slot;
  pts_t                 b_pts;
  logic [RW-1:0]        b_r1, b_r2;
  logic signed [DW-1:0] b_dx, b_dy;
  logic [CW-1:0]        b_rdc;
  logic signed [CW-1:0] b_rdo;

  always_ff @(posedge clk) begin
    b_slot <= a_slot;
    b_pts  <= a_pts;
    b_r1   <= a_r1;
    b_r2   <= a_r2;
    b_dx   <= DW'(a_pts.x2) - DW'(a_pts.x1);
    b_dy   <= DW'(a_pts.y2) - DW'(a_pts.y1);
    b_rdc  <= CW'(a_r1) + CW'(a_r2);
    b_rdo  <= $signed({1'b0, a_r1}) - $signed({1'b0, a_r2});
  end

  // stage c: squares
  logic                 c_valid;
  logic [1:0]           c_slot;
  pts_t                 c_pts;
  logic [RW-1:0]        c_r1, c_r2;
  logic signed [DW-1:0] c_dx, c_dy, c_rd;
  logic [SQW-1:0]       c_dx2, c_dy2, c_rdc2, c_rdo2;

  always_ff @(posedge clk) begin
    c_slot <= b_slot;
    c_pts  <= b_pts;
    c_r1   <= b_r1;
    c_r2   <= b_r2;
    c_dx   <= b_dx;
    c_dy   <= b_dy;
    c_rd   <= b_slot[1] ? DW'(b_rdo) : $signed(DW'(b_rdc));
    c_dx2  <= SQW'(b_dx) * SQW'(b_dx);
    c_dy2  <= SQW'(b_dy) * SQW'(b_dy);
    c_rdc2 <= SQW'(b_rdc) * SQW'(b_rdc);
    c_rdo2 <= SQW'(b_rdo) * SQW'(b_rdo);
  end

  // stage d: squared center distance
  logic                 d_valid;
  logic [1:0]           d_slot;
  pts_t                 d_pts;
  logic [RW-1:0]        d_r1, d_r2;
  logic signed [DW-1:0] d_dx, d_dy, d_rd;
  logic [SQW-1:0]       d_dd, d_rdc2, d_rdo2;

  always_ff @(posedge clk) begin
    d_slot <= c_slot;
    d_pts  <= c_pts;
    d_r1   <= c_r1;
    d_r2   <= c_r2;
    d_dx   <= c_dx;
    d_dy   <= c_dy;
    d_rd   <= c_rd;
    d_dd   <= c_dx2 + c_dy2;
    d_rdc2 <= c_rdc2;
    d_rdo2 <= c_rdo2;
  end

  // stage e: group checks and slot decode
  logic [SQW:0]   slack_sum;
  logic           en_cross, en_outer, concentric, none, emit;
  logic [SQW-1:0] rd2_sel, diff;
  ctl_t           ctl_e;

  always_comb begin
    slack_sum  = {1'b0, d_dd} + (SQW + 1)'(tangent_slack);
    en_cross   = !(slack_sum < (SQW + 1)'(d_rdc2));
    en_outer   = !(slack_sum < (SQW + 1)'(d_rdo2));
    concentric = d_dd <= SQW'(coincide_limit);
    none       = concentric || (!en_cross && !en_outer);
    rd2_sel    = d_slot[1] ? d_rdo2 : d_rdc2;
    diff       = (rd2_sel < d_dd) ? d_dd - rd2_sel : '0;
    // with no tangent only the first slot reports
    emit = none ? (!d_slot[1] && !d_slot[0]) : (d_slot[1] ? en_outer : en_cross);
    ctl_e.found    = !none;
    ctl_e.crossing = !none && !d_slot[1];
    ctl_e.side     = !none && d_slot[0];
    ctl_e.last     = none || (d_slot[0] && (d_slot[1] || !en_outer));
  end

  logic           e_valid;
  geo_t           e_geo;
  logic [SQW-1:0] e_diff;

  always_ff @(posedge clk) begin
    e_diff     <= diff;
    e_geo.ctl  <= ctl_e;
    e_geo.pts  <= d_pts;
    e_geo.r1   <= d_r1;
    e_geo.r2   <= d_r2;
    e_geo.dx   <= d_dx;
    e_geo.dy   <= d_dy;
    e_geo.rd   <= d_rd;
    e_geo.d    <= d_dd;
  end

  // tangent length
  logic [ROOTW-1:0]    s_root;
  geo_t                geo_dly [0:SQRT_LAT-1];
  logic [SQRT_LAT-1:0] sq_vld;
  geo_t                s_geo;

  cpts_isqrt u_isqrt (
    .clk      (clk),
    .radicand (e_diff),
    .root     (s_root)
  );

  always_ff @(posedge clk) begin
    geo_dly[0] <= e_geo;
    for (int i = 1; i < SQRT_LAT; i++) begin
      geo_dly[i] <= geo_dly[i-1];
    end
  end

  assign s_geo = geo_dly[SQRT_LAT-1];

  // n1: cross products
  logic                 n1_valid;
  rest_t                n1_rest;
  logic                 n1_side;
  logic signed [NW-1:0] n1_dxrd, n1_dyl, n1_dyrd, n1_dxl;
  logic signed [NW-1:0] len_s;

  assign len_s = $signed(NW'(s_root));

  always_ff @(posedge clk) begin
    n1_rest.ctl <= s_geo.ctl;
    n1_rest.pts <= s_geo.pts;
    n1_rest.r1  <= s_geo.r1;
    n1_rest.r2  <= s_geo.r2;
    n1_rest.d   <= s_geo.d;
    n1_side     <= s_geo.ctl.side;
    n1_dxrd     <= NW'(s_geo.dx) * NW'(s_geo.rd);
    n1_dyl      <= NW'(s_geo.dy) * len_s;
    n1_dyrd     <= NW'(s_geo.dy) * NW'(s_geo.rd);
    n1_dxl      <= NW'(s_geo.dx) * len_s;
  end

  // n2: direction vector
  logic                 n2_valid;
  rest_t                n2_rest;
  logic signed [NW-1:0] n2_nx, n2_ny;

  always_ff @(posedge clk) begin
    n2_rest <= n1_rest;
    n2_nx   <= n1_side ? n1_dxrd - n1_dyl : n1_dxrd + n1_dyl;
    n2_ny   <= n1_side ? n1_dyrd + n1_dxl : n1_dyrd - n1_dxl;
  end

  // n3: sign and magnitude
  logic          n3_valid;
  rest_t         n3_rest;
  logic          n3_negx, n3_negy;
  logic [MW-1:0] n3_mx, n3_my;
  logic [NW-1:0] absx, absy;

  assign absx = n2_nx[NW-1] ? NW'(-n2_nx) : NW'(n2_nx);
  assign absy = n2_ny[NW-1] ? NW'(-n2_ny) : NW'(n2_ny);

  always_ff @(posedge clk) begin
    n3_rest <= n2_rest;
    n3_negx <= n2_nx[NW-1];
    n3_negy <= n2_ny[NW-1];
    n3_mx   <= absx[MW-1:0];
    n3_my   <= absy[MW-1:0];
  end

  // n4: radius times magnitude, split in two partial products
  logic                      n4_valid;
  rest_t                     n4_rest;
  logic                      n4_negx, n4_negy;
  logic [LOW_W+RW-1:0]       n4_lx1, n4_ly1, n4_lx2, n4_ly2;
  logic [HIGH_W+RW-1:0]      n4_hx1, n4_hy1, n4_hx2, n4_hy2;

  always_ff @(posedge clk) begin
    n4_rest <= n3_rest;
    n4_negx <= n3_negx;
    n4_negy <= n3_negy;
    n4_lx1  <= (LOW_W + RW)'(n3_mx[LOW_W-1:0]) * (LOW_W + RW)'(n3_rest.r1);
    n4_ly1  <= (LOW_W + RW)'(n3_my[LOW_W-1:0]) * (LOW_W + RW)'(n3_rest.r1);
    n4_lx2  <= (LOW_W + RW)'(n3_mx[LOW_W-1:0]) * (LOW_W + RW)'(n3_rest.r2);
    n4_ly2  <= (LOW_W + RW)'(n3_my[LOW_W-1:0]) * (LOW_W + RW)'(n3_rest.r2);
    n4_hx1  <= (HIGH_W + RW)'(n3_mx[MW-1:LOW_W]) * (HIGH_W + RW)'(n3_rest.r1);
    n4_hy1  <= (HIGH_W + RW)'(n3_my[MW-1:LOW_W]) * (HIGH_W + RW)'(n3_rest.r1);
    n4_hx2  <= (HIGH_W + RW)'(n3_mx[MW-1:LOW_W]) * (HIGH_W + RW)'(n3_rest.r2);
    n4_hy2  <= (HIGH_W + RW)'(n3_my[MW-1:LOW_W]) * (HIGH_W + RW)'(n3_rest.r2);
  end

  // n5: full products
  logic          n5_valid;
  rest_t         n5_rest;
  logic          n5_negx, n5_negy;
  logic [PW-1:0] n5_px1, n5_py1, n5_px2, n5_py2;

  always_ff @(posedge clk) begin
    n5_rest <= n4_rest;
    n5_negx <= n4_negx;
    n5_negy <= n4_negy;
    n5_px1  <= PW'(n4_lx1) + (PW'(n4_hx1) << LOW_W);
    n5_py1  <= PW'(n4_ly1) + (PW'(n4_hy1) << LOW_W);
    n5_px2  <= PW'(n4_lx2) + (PW'(n4_hx2) << LOW_W);
    n5_py2  <= PW'(n4_ly2) + (PW'(n4_hy2) << LOW_W);
  end

  // n6: rounding numerators, (2p + d) / 2d rounds half away from zero
  logic            n6_valid;
  fin_t            n6_fin;
  logic [NUMW-1:0] n6_ux1, n6_uy1, n6_ux2, n6_uy2;
  logic [DENW-1:0] n6_den;

  always_ff @(posedge clk) begin
    n6_fin.ctl  <= n5_rest.ctl;
    n6_fin.pts  <= n5_rest.pts;
    n6_fin.negx <= n5_negx;
    n6_fin.negy <= n5_negy;
    n6_ux1      <= {n5_px1, 1'b0} + NUMW'(n5_rest.d);
    n6_uy1      <= {n5_py1, 1'b0} + NUMW'(n5_rest.d);
    n6_ux2      <= {n5_px2, 1'b0} + NUMW'(n5_rest.d);
    n6_uy2      <= {n5_py2, 1'b0} + NUMW'(n5_rest.d);
    n6_den      <= {n5_rest.d, 1'b0};
  end

  logic [QW-1:0] q_x1, q_y1, q_x2, q_y2;

  cpts_div u_div_x1 (.clk(clk), .numer(n6_ux1), .denom(n6_den), .quot(q_x1));
  cpts_div u_div_y1 (.clk(clk), .numer(n6_uy1), .denom(n6_den), .quot(q_y1));
  cpts_div u_div_x2 (.clk(clk), .numer(n6_ux2), .denom(n6_den), .quot(q_x2));
  cpts_div u_div_y2 (.clk(clk), .numer(n6_uy2), .denom(n6_den), .quot(q_y2));

  fin_t               fin_dly [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] dv_vld;
  fin_t               f;

  always_ff @(posedge clk) begin
    fin_dly[0] <= n6_fin;
    for (int i = 1; i < DIV_LAT; i++) begin
      fin_dly[i] <= fin_dly[i-1];
    end
  end

  assign f = fin_dly[DIV_LAT-1];

  // valid bits travel beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      d_valid  <= 1'b0;
      e_valid  <= 1'b0;
      sq_vld   <= '0;
      n1_valid <= 1'b0;
      n2_valid <= 1'b0;
      n3_valid <= 1'b0;
      n4_valid <= 1'b0;
      n5_valid <= 1'b0;
      n6_valid <= 1'b0;
      dv_vld   <= '0;
      valid    <= 1'b0;
    end else begin
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      d_valid  <= c_valid;
      e_valid  <= d_valid && emit;
      sq_vld   <= {sq_vld[SQRT_LAT-2:0], e_valid};
      n1_valid <= sq_vld[SQRT_LAT-1];
      n2_valid <= n1_valid;
      n3_valid <= n2_valid;
      n4_valid <= n3_valid;
      n5_valid <= n4_valid;
      n6_valid <= n5_valid;
      dv_vld   <= {dv_vld[DIV_LAT-2:0], n6_valid};
      valid    <= dv_vld[DIV_LAT-1];
    end
  end

  // output stage: offsets applied to centers, second circle mirrored for crossing
  always_ff @(posedge clk) begin
    found    <= f.ctl.found;
    crossing <= f.ctl.crossing;
    side     <= f.ctl.side;
    last     <= f.ctl.last;
    if (f.ctl.found) begin
      touch_first_x  <= offset_sat(f.pts.x1, q_x1, f.negx);
      touch_first_y  <= offset_sat(f.pts.y1, q_y1, f.negy);
      touch_second_x <= offset_sat(f.pts.x2, q_x2, f.negx ^ f.ctl.crossing);
      touch_second_y <= offset_sat(f.pts.y2, q_y2, f.negy ^ f.ctl.crossing);
    end else begin
      touch_first_x  <= '0;
      touch_first_y  <= '0;
      touch_second_x <= '0;
      touch_second_y <= '0;
    end
  end

endmodule

// ----- tb/tb_circle_pair_tangent_segments_top.sv -----
`timescale 1ns / 100ps

module tb_circle_pair_tangent_segments_top;
  import cpts_pkg::*;

  typedef logic signed [159:0] big_t;

  typedef struct {
    logic found;
    logic crossing;
    logic side;
    logic last;
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
  } segment_t;

  class tangent_scoreboard;
    segment_t pending_segments[$];
    logic [CW-1:0] coincide_lim;
    logic [CW-1:0] slack;
    int mismatches;

    function new();
      coincide_lim = COINCIDE_RESET;
      slack = SLACK_RESET;
      mismatches = 0;
    endfunction

    function big_t root_floor(big_t v);
      big_t res;
      big_t c;
      res = 0;
      for (int b = 40; b >= 0; b--) begin
        c = res | (big_t'(1) <<< b);
        if (c * c <= v) res = c;
      end
      return res;
    endfunction

    // round(r * n / d) half away from zero, magnitude clipped to 2^40
    function big_t offset(big_t r, big_t n, big_t d);
      big_t mag;
      big_t q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag * r + d) / (2 * d);
      if (q > (big_t'(1) <<< 40)) q = big_t'(1) <<< 40;
      return (n < 0) ? -q : q;
    endfunction

    function logic signed [CW-1:0] clamp(big_t v);
      if (v > big_t'(2147483647)) return 32'sh7fffffff;
      if (v < -big_t'(2147483647) - 1) return 32'sh80000000;
      return v[CW-1:0];
    endfunction

    function void add_pair(logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                           logic [RW-1:0] r1, logic signed [CW-1:0] x2,
                           logic signed [CW-1:0] y2, logic [RW-1:0] r2);
      big_t bx1, by1, bx2, by2, br1, br2, dx, dy, d, rd, rd2, len, nx, ny, s;
      segment_t seg;
      int count;
      bx1 = x1; by1 = y1; bx2 = x2; by2 = y2;
      br1 = big_t'({1'b0, r1});
      br2 = big_t'({1'b0, r2});
      dx = bx2 - bx1;
      dy = by2 - by1;
      d = dx * dx + dy * dy;
      count = 0;
      if (d > big_t'({1'b0, coincide_lim})) begin
        for (int g = 0; g < 2; g++) begin
          rd = (g == 0) ? br1 + br2 : br1 - br2;
          s = (g == 0) ? -1 : 1;
          rd2 = rd * rd;
          if (d + big_t'({1'b0, slack}) < rd2) continue;
          len = (rd2 < d) ? root_floor(d - rd2) : 0;
          for (int k = 0; k < 2; k++) begin
            if (k == 0) begin
              nx = dx * rd + dy * len;
              ny = dy * rd - dx * len;
            end else begin
              nx = dx * rd - dy * len;
              ny = dy * rd + dx * len;
            end
            seg.found = 1'b1;
            seg.crossing = (g == 0);
            seg.side = k[0];
            seg.last = 1'b0;
            seg.fx = clamp(bx1 + offset(br1, nx, d));
            seg.fy = clamp(by1 + offset(br1, ny, d));
            seg.sx = clamp(bx2 + s * offset(br2, nx, d));
            seg.sy = clamp(by2 + s * offset(br2, ny, d));
            pending_segments = {pending_segments, seg};
            count++;
          end
        end
      end
      if (count == 0) begin
        seg = '{1'b0, 1'b0, 1'b0, 1'b1, '0, '0, '0, '0};
        pending_segments = {pending_segments, seg};
      end else begin
        pending_segments[$].last = 1'b1;
      end
    endfunction

    function void check_segment(segment_t got);
      segment_t want;
      if (pending_segments.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = pending_segments.pop_front();
      if (got.found !== want.found || got.crossing !== want.crossing ||
          got.side !== want.side || got.last !== want.last ||
          got.fx !== want.fx || got.fy !== want.fy ||
          got.sx !== want.sx || got.sy !== want.sy) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [CW-1:0] first_center_x, first_center_y, second_center_x, second_center_y;
  logic [RW-1:0] first_radius, second_radius;
  logic wr_en;
  logic [IDXW-1:0] wr_index;
  logic [CW-1:0] wr_data;
  logic valid, found, crossing, side, last;
  logic signed [CW-1:0] touch_first_x, touch_first_y, touch_second_x, touch_second_y;

  tangent_scoreboard book;
  int idle_pct;
  int quiet_cycles;

  circle_pair_tangent_segments_top dut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    if (!rst && valid) begin
      book.check_segment('{found, crossing, side, last, touch_first_x, touch_first_y,
                           touch_second_x, touch_second_y});
    end
  end

  // watchdog on cycles with no item taken and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
        $display("tb_circle_pair_tangent_segments_top: errors");
        $finish;
      end
    end
  end

  // leaves start high after the accept; settle() or an idle cycle of the next call lowers it
  task automatic send_pair(logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                           logic [RW-1:0] r1, logic signed [CW-1:0] x2,
                           logic signed [CW-1:0] y2, logic [RW-1:0] r2);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    first_center_x = x1;
    first_center_y = y1;
    first_radius = r1;
    second_center_x = x2;
    second_center_y = y2;
    second_radius = r2;
    do @(posedge clk); while (busy);
    book.add_pair(x1, y1, r1, x2, y2, r2);
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (book.pending_segments.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_regs(logic [CW-1:0] lim, logic [CW-1:0] slk);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = REG_COINCIDE_LIMIT;
    wr_data = lim;
    @(negedge clk);
    wr_index = REG_TANGENT_SLACK;
    wr_data = slk;
    @(negedge clk);
    wr_en = 1'b0;
    book.coincide_lim = lim;
    book.slack = slk;
  endtask

  task automatic random_pair();
    longint x1, y1, x2, y2, r1, r2, k, rd;
    int kind;
    kind = $urandom_range(0, 9);
    x1 = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    y1 = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    x2 = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    y2 = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    r1 = $urandom_range(0, 1 << 22);
    r2 = $urandom_range(0, 1 << 22);
    case (kind)
      0, 1: begin
        x1 = $signed($urandom); y1 = $signed($urandom);
        x2 = $signed($urandom); y2 = $signed($urandom);
        r1 = $urandom & 32'h7fffffff;
        r2 = $urandom & 32'h7fffffff;
      end
      6: begin
        // touching circles, rd^2 close to the squared distance
        k = $urandom_range(1, 4000);
        x2 = x1 + 3 * k;
        y2 = y1 + 4 * k;
        rd = 5 * k + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 1)) begin
          r1 = $urandom_range(0, int'(rd));
          r2 = rd - r1;
        end else begin
          r2 = $urandom_range(0, 1 << 20);
          r1 = r2 + rd;
        end
      end
      7: begin
        x2 = x1 + $urandom_range(0, 600) - 300;
        y2 = y1 + $urandom_range(0, 600) - 300;
      end
      8: begin
        r1 = $urandom_range(1 << 20, 1 << 22);
        r2 = $urandom_range(0, 1 << 16);
        x2 = x1 + $urandom_range(0, 1 << 18);
        y2 = y1 - $urandom_range(0, 1 << 18);
      end
      9: begin
        x1 = $signed($urandom); x2 = $signed($urandom);
        r1 = 32'h7fffffff - $urandom_range(0, 1 << 20);
        r2 = 32'h7fffffff - $urandom_range(0, 1 << 20);
      end
      default: ;
    endcase
    send_pair(x1[31:0], y1[31:0], r1[30:0], x2[31:0], y2[31:0], r2[30:0]);
  endtask

  initial begin
    book = new();
    idle_pct = 27;
    rst = 1'b1;
    start = 1'b0;
    wr_en = 1'b0;
    wr_index = REG_COINCIDE_LIMIT;
    wr_data = '0;
    first_center_x = '0; first_center_y = '0; first_radius = '0;
    second_center_x = '0; second_center_y = '0; second_radius = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed items at reset settings
    send_pair(0, 0, 65536, 32'sh50000, 0, 65536);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(100, -100, 5, 100, -100, 7);
    send_pair(0, 0, 3, 3, 4, 2);
    send_pair(0, 0, 9, 3, 4, 4);
    send_pair(0, 0, 1, 1, 1, 1);
    send_pair(0, 0, 100, 10, 0, 2);
    send_pair(32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
              32'sh80000000, 32'sh80000000, 31'h7fffffff);
    send_pair(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000, 0);
    send_pair(32'sh7fffffff, 0, 31'h7fffffff, 32'sh7ffffff0, 0, 1);
    send_pair(-65536, 65536, 31'h7fffffff, 65536, -65536, 0);
    send_pair(1000, 2000, 31'h7fffffff, -3000, 5000, 31'h7ffffffe);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph % 3 == 0) ? 27 : (ph % 3 == 1) ? 87 : 0;
      case (ph)
        0: set_regs(0, 0);
        1: set_regs(32'hffffffff, 32'hffffffff);
        2: set_regs($urandom_range(0, 1 << 20), $urandom_range(0, 64));
        3: set_regs($urandom, $urandom);
        4: set_regs(COINCIDE_RESET, SLACK_RESET);
        default: set_regs($urandom_range(0, 1000), 0);
      endcase
      repeat (70) random_pair();
      settle();
    end

    if (book.mismatches == 0 && book.pending_segments.size() == 0) begin
      $display("tb_circle_pair_tangent_segments_top: clean");
    end else begin
      $display("tb_circle_pair_tangent_segments_top: errors");
    end
    $finish;
  end

endmodule
